// ===== hw/rtl/pccc_pkg.sv =====
// ----------------------------------------------------------------------------
// pccc_pkg
// Shared codes and reset values for the PIN change controller.
// ----------------------------------------------------------------------------
package pccc_pkg;

  // Default number of digits in one PIN entry
  localparam int unsigned PinDigitsDef = 4;

  // Key actions
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_CANCEL = 3'd1;
  localparam logic [2:0] ACT_DIG0   = 3'd2;
  localparam logic [2:0] ACT_DIG1   = 3'd3;
  localparam logic [2:0] ACT_OTHER  = 3'd4;
  localparam logic [2:0] ACT_START  = 3'd5;

  // Result status codes
  localparam logic [2:0] ST_ENTERING = 3'd0;
  localparam logic [2:0] ST_TIMEOUT  = 3'd1;
  localparam logic [2:0] ST_CANCEL   = 3'd2;
  localparam logic [2:0] ST_SAVED    = 3'd3;
  localparam logic [2:0] ST_MISMATCH = 3'd4;
  localparam logic [2:0] ST_INACTIVE = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] REG_BLINK    = 2'd0;
  localparam logic [1:0] REG_IDLE     = 2'd1;
  localparam logic [1:0] REG_COOLDOWN = 2'd2;

  // Configuration reset values
  localparam logic [7:0] BLINK_RST    = 8'd20;
  localparam logic [7:0] IDLE_RST     = 8'd100;
  localparam logic [1:0] COOLDOWN_RST = 2'd2;

endpackage

// ===== hw/rtl/pin_change_confirm_controller.sv =====
// ----------------------------------------------------------------------------
// pin_change_confirm_controller
// PIN change dialog: two binary PIN entries with blink cooldown and timeout.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | sink      | in_valid_i/in_stall_o| action, fast_tick, slow_tick
//  out     | source    | out_valid_o/out_stall_i | status, confirm_phase,
//          |           |                      | digits_entered, cursor_on,
//          |           |                      | saved_pin
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One beat in, one beat out. An accepted beat is held in the input register,
// then the dialog update writes the state and the result register, which
// presents the result; one beat per cycle is sustained while the output is
// not stalled. Reset clears the dialog and loads the default register values.
// A stalled output holds the result; the input register keeps the next beat
// and the input stalls only when both are full and the output is stalled.
// ----------------------------------------------------------------------------
module pin_change_confirm_controller
  import pccc_pkg::*;
#(
  parameter int unsigned PIN_DIGITS = PinDigitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input items
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [2:0] action_i,
  input  logic       fast_tick_i,
  input  logic       slow_tick_i,
  // result items
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] status_o,
  output logic       confirm_phase_o,
  output logic [2:0] digits_entered_o,
  output logic       cursor_on_o,
  output logic [3:0] saved_pin_o,
  // configuration writes
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int unsigned PW = PIN_DIGITS;
  localparam int unsigned CW = $clog2(PIN_DIGITS + 1);
  localparam logic [CW-1:0] PIN_CNT = CW'(PIN_DIGITS);
  localparam logic [2:0]    PIN_CNT_LO = 3'(PIN_DIGITS);

  // configuration registers
  logic [7:0] blink_q, idle_q;
  logic [1:0] cool_lim_q;

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [2:0] s1_act_q;
  logic       s1_fast_q, s1_slow_q;

  // dialog state
  logic          active_q, active_d;
  logic          phase_q, phase_d;
  logic [PW-1:0] pin1_q, pin1_d;
  logic [PW-1:0] pin2_q, pin2_d;
  logic [CW-1:0] count_q, count_d;
  logic          cursor_q, cursor_d;
  logic [1:0]    cool_q, cool_d;
  logic [7:0]    fast_q, fast_d;
  logic [7:0]    slow_q, slow_d;

  // result register
  logic       out_valid_q;
  logic [2:0] res_status_q, res_status_d;
  logic       res_phase_q, res_phase_d;
  logic [2:0] res_count_q, res_count_d;
  logic       res_cursor_q, res_cursor_d;
  logic [3:0] res_pin_q, res_pin_d;

  logic in_fire, advance;

  // handshake
  assign advance    = s1_valid_q & ~(out_valid_q & out_stall_i);
  assign in_stall_o = s1_valid_q & ~advance;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign s1_valid_d = in_fire | (s1_valid_q & ~advance);
  assign cfg_ready_o = 1'b1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blink_q    <= BLINK_RST;
      idle_q     <= IDLE_RST;
      cool_lim_q <= COOLDOWN_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BLINK:    blink_q    <= cfg_data_i;
        REG_IDLE:     idle_q     <= cfg_data_i;
        REG_COOLDOWN: cool_lim_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_act_q  <= action_i;
      s1_fast_q <= fast_tick_i;
      s1_slow_q <= slow_tick_i;
    end
  end

  // dialog update for the beat in the input register
  always_comb begin
    logic [CW+2:0] cnt_ext;
    logic [PW+3:0] pin_ext;
    logic          match;

    active_d = active_q;
    phase_d  = phase_q;
    pin1_d   = pin1_q;
    pin2_d   = pin2_q;
    count_d  = count_q;
    cursor_d = cursor_q;
    cool_d   = cool_q;
    fast_d   = fast_q;
    slow_d   = slow_q;
    cnt_ext  = '0;
    pin_ext  = '0;
    match    = 1'b0;

    res_status_d = ST_ENTERING;
    res_phase_d  = 1'b0;
    res_count_d  = '0;
    res_cursor_d = 1'b0;
    res_pin_d    = '0;

    if (s1_act_q == ACT_START) begin
      // start: fresh dialog from any state
      active_d     = 1'b1;
      phase_d      = 1'b0;
      pin1_d       = '0;
      pin2_d       = '0;
      count_d      = '0;
      cursor_d     = 1'b1;
      cool_d       = '0;
      fast_d       = '0;
      slow_d       = '0;
      res_cursor_d = 1'b1;
    end else if (!active_q) begin
      res_status_d = ST_INACTIVE;
    end else begin
      // saturating tick counters
      if (s1_fast_q && fast_q != 8'hFF) fast_d = fast_q + 8'd1;
      if (s1_slow_q && slow_q != 8'hFF) slow_d = slow_q + 8'd1;

      // blink period elapsed
      if (fast_d >= blink_q) begin
        fast_d   = '0;
        cursor_d = ~cursor_q;
        if (cool_q < cool_lim_q) cool_d = cool_q + 2'd1;
      end

      if (s1_act_q == ACT_NONE && slow_d >= idle_q) begin
        active_d     = 1'b0;
        res_status_d = ST_TIMEOUT;
      end else begin
        if (s1_act_q != ACT_NONE) slow_d = '0;

        if (s1_act_q == ACT_CANCEL) begin
          active_d     = 1'b0;
          res_status_d = ST_CANCEL;
        end else if (cool_d >= cool_lim_q) begin
          // digit capture
          if (count_q < PIN_CNT && (s1_act_q == ACT_DIG0 || s1_act_q == ACT_DIG1)) begin
            for (int k = 0; k < PW; k++) begin
              if (count_q == CW'(k)) begin
                if (phase_q) pin2_d[k] = (s1_act_q == ACT_DIG1);
                else         pin1_d[k] = (s1_act_q == ACT_DIG1);
              end
            end
            count_d  = count_q + CW'(1);
            cursor_d = 1'b1;
            fast_d   = '0;
          end

          // entry complete
          if (count_d >= PIN_CNT) begin
            if (!phase_d) begin
              phase_d  = 1'b1;
              count_d  = '0;
              cursor_d = 1'b1;
              fast_d   = '0;
            end else begin
              match        = (pin1_d == pin2_d);
              pin_ext      = {4'b0, pin1_d};
              res_phase_d  = 1'b1;
              res_count_d  = PIN_CNT_LO;
              res_cursor_d = cursor_d;
              if (match) begin
                res_status_d = ST_SAVED;
                res_pin_d    = pin_ext[3:0];
                active_d     = 1'b0;
              end else begin
                res_status_d = ST_MISMATCH;
              end
              phase_d  = 1'b0;
              pin1_d   = '0;
              pin2_d   = '0;
              count_d  = '0;
              cursor_d = 1'b1;
              cool_d   = '0;
              fast_d   = '0;
              slow_d   = '0;
            end
          end
        end
      end

      // status other than saved/mismatch shows the live entry view
      if (res_status_d != ST_SAVED && res_status_d != ST_MISMATCH) begin
        cnt_ext      = {3'b0, count_d};
        res_phase_d  = phase_d;
        res_count_d  = cnt_ext[2:0];
        res_cursor_d = cursor_d;
      end
    end
  end

  // dialog state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      phase_q  <= 1'b0;
      pin1_q   <= '0;
      pin2_q   <= '0;
      count_q  <= '0;
      cursor_q <= 1'b1;
      cool_q   <= '0;
      fast_q   <= '0;
      slow_q   <= '0;
    end else if (advance) begin
      active_q <= active_d;
      phase_q  <= phase_d;
      pin1_q   <= pin1_d;
      pin2_q   <= pin2_d;
      count_q  <= count_d;
      cursor_q <= cursor_d;
      cool_q   <= cool_d;
      fast_q   <= fast_d;
      slow_q   <= slow_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_status_q <= res_status_d;
      res_phase_q  <= res_phase_d;
      res_count_q  <= res_count_d;
      res_cursor_q <= res_cursor_d;
      res_pin_q    <= res_pin_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_status_q;
  assign confirm_phase_o  = res_phase_q;
  assign digits_entered_o = res_count_q;
  assign cursor_on_o      = res_cursor_q;
  assign saved_pin_o      = res_pin_q;

  // checks
  a_saved_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_SAVED |-> confirm_phase_o && digits_entered_o == PIN_CNT_LO)
    else $error("saved result without full confirmation entry");

  a_pin_only_saved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_SAVED |-> saved_pin_o == 4'd0)
    else $error("PIN shown outside a saved result");

  a_inactive_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_INACTIVE
      |-> !confirm_phase_o && digits_entered_o == 3'd0 && !cursor_on_o)
    else $error("inactive result carries entry fields");

  a_exit_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (res_status_d == ST_SAVED || res_status_d == ST_TIMEOUT ||
                res_status_d == ST_CANCEL) |=> !active_q)
    else $error("dialog still armed after exit");

endmodule

// ===== tb/pin_dialog_checker.sv =====
// ----------------------------------------------------------------------------
// pin_dialog_checker
// Watches the item, result and register channels of the PIN change
// controller, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module pin_dialog_checker
  import pccc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  // item channel
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [2:0] action_i,
  input  logic       fast_tick_i,
  input  logic       slow_tick_i,
  // result channel
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [2:0] status_i,
  input  logic       confirm_phase_i,
  input  logic [2:0] digits_entered_i,
  input  logic       cursor_on_i,
  input  logic [3:0] saved_pin_i,
  // register channel
  input  logic       cfg_valid_i,
  input  logic       cfg_ready_i,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  // to the top
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0] status;
    logic       phase;
    logic [2:0] digits;
    logic       cursor;
    logic [3:0] pin;
  } dialog_result_t;

  // register copies
  logic [7:0] blink_thr;
  logic [7:0] idle_lim;
  logic [1:0] cool_lim;

  // dialog state
  logic                    armed;
  logic                    confirming;
  logic [PinDigitsDef-1:0] pin_first;
  logic [PinDigitsDef-1:0] pin_second;
  logic [2:0]              ndigits;
  logic                    cursor;
  logic [1:0]              cool_cnt;
  logic [7:0]              fast_cnt;
  logic [7:0]              slow_cnt;

  dialog_result_t expected_results[$];
  int             fails;

  // Entry state back to a fresh first entry; armed is left alone
  function automatic void restart_entry();
    confirming = 1'b0;
    pin_first  = '0;
    pin_second = '0;
    ndigits    = '0;
    cursor     = 1'b1;
    cool_cnt   = '0;
    fast_cnt   = '0;
    slow_cnt   = '0;
  endfunction

  // One item through the dialog; returns the result beat it produces
  function automatic dialog_result_t advance_dialog(input logic [2:0] act, input logic ft,
                                                    input logic st);
    dialog_result_t res;
    res = '0;
    // start rearms from any state
    if (act == ACT_START) begin
      restart_entry();
      armed      = 1'b1;
      res.status = ST_ENTERING;
      res.cursor = 1'b1;
      return res;
    end
    if (!armed) begin
      res.status = ST_INACTIVE;
      return res;
    end

    // saturating tick counters
    if (ft && fast_cnt != 8'hFF) fast_cnt++;
    if (st && slow_cnt != 8'hFF) slow_cnt++;

    // blink period elapsed: toggle cursor, step cooldown
    if (fast_cnt >= blink_thr) begin
      fast_cnt = '0;
      cursor   = ~cursor;
      if (cool_cnt < cool_lim) cool_cnt++;
    end

    res.phase  = confirming;
    res.digits = ndigits;
    res.cursor = cursor;

    if (act == ACT_NONE && slow_cnt >= idle_lim) begin
      armed      = 1'b0;
      res.status = ST_TIMEOUT;
      return res;
    end
    if (act != ACT_NONE) slow_cnt = '0;
    if (act == ACT_CANCEL) begin
      armed      = 1'b0;
      res.status = ST_CANCEL;
      return res;
    end

    // digits only count once cooldown is over
    if (cool_cnt >= cool_lim) begin
      if (ndigits < PinDigitsDef && (act == ACT_DIG0 || act == ACT_DIG1)) begin
        if (confirming) pin_second[ndigits] = (act == ACT_DIG1);
        else            pin_first[ndigits]  = (act == ACT_DIG1);
        ndigits++;
        cursor   = 1'b1;
        fast_cnt = '0;
      end
      if (ndigits >= PinDigitsDef) begin
        if (!confirming) begin
          confirming = 1'b1;
          ndigits    = '0;
          cursor     = 1'b1;
          fast_cnt   = '0;
        end else begin
          res.phase  = 1'b1;
          res.digits = 3'(PinDigitsDef);
          res.cursor = cursor;
          if (pin_first == pin_second) begin
            res.status = ST_SAVED;
            res.pin    = pin_first;
            armed      = 1'b0;
          end else begin
            res.status = ST_MISMATCH;
          end
          restart_entry();
          return res;
        end
      end
    end

    res.status = ST_ENTERING;
    res.phase  = confirming;
    res.digits = ndigits;
    res.cursor = cursor;
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  // Track register writes, queue predictions, retire result beats
  always @(posedge clk_i or negedge rst_ni) begin
    dialog_result_t want;
    if (!rst_ni) begin
      blink_thr = BLINK_RST;
      idle_lim  = IDLE_RST;
      cool_lim  = COOLDOWN_RST;
      armed     = 1'b0;
      restart_entry();
      expected_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_BLINK:    blink_thr = cfg_data_i;
          REG_IDLE:     idle_lim  = cfg_data_i;
          REG_COOLDOWN: cool_lim  = cfg_data_i[1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(advance_dialog(action_i, fast_tick_i, slow_tick_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no prediction waiting (status %0d)", status_i);
          fails++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, status_i);
          check_field("confirm_phase", want.phase, confirm_phase_i);
          check_field("digits_entered", want.digits, digits_entered_i);
          check_field("cursor_on", want.cursor, cursor_on_i);
          check_field("saved_pin", want.pin, saved_pin_i);
        end
      end
    end
    pending_o    <= expected_results.size();
    fail_count_o <= fails;
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the PIN change controller with directed dialogs and random key and
// tick streams over several register settings and flow-control mixes; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module testbench
  import pccc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // actions the block treats like any other key
  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [2:0] action      = ACT_NONE;
  logic       fast_tick   = 1'b0;
  logic       slow_tick   = 1'b0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [2:0] status;
  logic       confirm_phase;
  logic [2:0] digits_entered;
  logic       cursor_on;
  logic [3:0] saved_pin;
  logic       cfg_valid   = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index   = REG_BLINK;
  logic [7:0] cfg_data    = '0;
  int         fail_count;
  int         pending;

  int         send_idle_pct = 26;
  int         recv_idle_pct = 79;
  logic [7:0] pin_plan      = '0;
  int         plan_pos      = 8;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pin_change_confirm_controller dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .action_i         (action),
    .fast_tick_i      (fast_tick),
    .slow_tick_i      (slow_tick),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .status_o         (status),
    .confirm_phase_o  (confirm_phase),
    .digits_entered_o (digits_entered),
    .cursor_on_o      (cursor_on),
    .saved_pin_o      (saved_pin),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data)
  );

  pin_dialog_checker checker_i (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .action_i         (action),
    .fast_tick_i      (fast_tick),
    .slow_tick_i      (slow_tick),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .status_i         (status),
    .confirm_phase_i  (confirm_phase),
    .digits_entered_i (digits_entered),
    .cursor_on_i      (cursor_on),
    .saved_pin_i      (saved_pin),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // one item beat, with random idle cycles ahead of it
  task automatic send_item(input logic [2:0] act, input logic ft, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    fast_tick <= ft;
    slow_tick <= st;
    // stall is settled mid-cycle; hold the beat until an edge takes it
    @(negedge clk);
    while (in_stall) begin
      @(posedge clk);
      @(negedge clk);
    end
    @(posedge clk);
  endtask

  // hold the sender until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all three registers, block idle
  task automatic program_regs(input logic [7:0] blink, input logic [7:0] idle,
                              input logic [1:0] cool);
    drain_results();
    write_reg(REG_BLINK, blink);
    write_reg(REG_IDLE, idle);
    write_reg(REG_COOLDOWN, {6'd0, cool});
    cfg_valid <= 1'b0;
  endtask

  // Mostly planned two-entry dialogs (often matching), with noise keys,
  // idle items, cancels and the odd restart mixed in
  task automatic random_item();
    int         pick;
    logic [2:0] act;
    pick = $urandom_range(99);
    if (plan_pos >= 8 || pick < 3) begin
      act           = ACT_START;
      pin_plan[3:0] = 4'($urandom);
      pin_plan[7:4] = ($urandom_range(99) < 60) ? pin_plan[3:0] : 4'($urandom);
      plan_pos      = 0;
    end else if (pick < 18) begin
      act = 3'($urandom_range(7));
    end else if (pick < 75) begin
      act = pin_plan[plan_pos] ? ACT_DIG1 : ACT_DIG0;
      plan_pos++;
    end else if (pick < 91) begin
      act = ACT_NONE;
    end else if (pick < 93) begin
      act = ACT_CANCEL;
    end else begin
      case ($urandom_range(2))
        0:       act = ACT_OTHER;
        1:       act = ACT_SPARE6;
        default: act = ACT_SPARE7;
      endcase
    end
    send_item(act, $urandom_range(99) < 60, $urandom_range(99) < 12);
  endtask

  task automatic run_segment(input logic [7:0] blink, input logic [7:0] idle,
                             input logic [1:0] cool, input int snd, input int rcv);
    program_regs(blink, idle, cool);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    repeat (125) random_item();
  endtask

  initial begin
    int k;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: inactive items, arm, digit swallowed by cooldown
    send_item(ACT_NONE, 1'b1, 1'b1);
    send_item(ACT_DIG1, 1'b0, 1'b0);
    send_item(ACT_START, 1'b0, 1'b0);
    send_item(ACT_DIG1, 1'b1, 1'b0);

    // fast blink, no cooldown, short idle limit
    program_regs(8'd1, 8'd2, 2'd0);
    send_item(ACT_DIG1, 1'b1, 1'b0);
    send_item(ACT_DIG0, 1'b0, 1'b0);
    send_item(ACT_DIG1, 1'b0, 1'b1);
    send_item(ACT_DIG0, 1'b1, 1'b0);
    // matching confirmation: saved
    for (k = 0; k < 4; k++) send_item(k[0] ? ACT_DIG0 : ACT_DIG1, k[1], 1'b0);
    // all zeros then all ones: mismatch
    send_item(ACT_START, 1'b1, 1'b1);
    for (k = 0; k < 8; k++) send_item(k < 4 ? ACT_DIG0 : ACT_DIG1, k[0], 1'b0);
    // unused codes and other key clear the idle count; then idle timeout
    send_item(ACT_SPARE6, 1'b0, 1'b1);
    send_item(ACT_SPARE7, 1'b1, 1'b1);
    send_item(ACT_OTHER, 1'b0, 1'b1);
    send_item(ACT_NONE, 1'b0, 1'b1);
    send_item(ACT_NONE, 1'b1, 1'b1);
    send_item(ACT_START, 1'b0, 1'b0);
    send_item(ACT_CANCEL, 1'b1, 1'b1);

    // random part: sender light / receiver heavy, then swapped, then free
    run_segment(8'd1,   8'd8,   2'd0, 26, 79);
    run_segment(8'd255, 8'd255, 2'd3, 26, 79);
    run_segment(8'd2,   8'd1,   2'd1, 79, 26);
    run_segment(8'd3,   8'd40,  2'd3, 79, 26);
    run_segment(8'd0,   8'd0,   2'd2, 0,  0);
    run_segment(8'd1,   8'd30,  2'd0, 0,  0);

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
